FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros included by the top-level RTL file
// Clocked, reset-gated implications for concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when a holds, b holds.
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication: when a holds, b holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: src/hmb_pkg.sv
// ----------------------------------------------------------------------------
// hmb_pkg
// Shared constants, cell record and inter-module structs of the binning block.
// ----------------------------------------------------------------------------
package hmb_pkg;

    localparam int MAX_CELLS  = 65536;
    localparam int CELL_IDX_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    // row (9 bits) times cells_across (9 bits) plus a column: 18 bits
    localparam int IDX_SUM_W  = 18;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // operation codes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // configuration register indexes
    localparam logic [7:0] CFG_CELLS_ACROSS = 8'd0;
    localparam logic [7:0] CFG_CELLS_DEEP   = 8'd1;
    localparam logic [7:0] CFG_X_SCALE      = 8'd2;
    localparam logic [7:0] CFG_Z_SCALE      = 8'd3;
    localparam logic [7:0] CFG_MIN_POINTS   = 8'd4;

    typedef struct packed {
        logic [14:0] height;
        logic [15:0] count;
    } cell_t;

    localparam int CELL_W = $bits(cell_t);

    typedef struct packed {
        logic load_prod;
        logic load_idx;
    } loc_ctrl_t;

    typedef struct packed {
        logic                  in_grid;
        logic [CELL_IDX_W-1:0] idx;
    } loc_res_t;

endpackage

FILE: src/hmb_cell_ram.sv
// ----------------------------------------------------------------------------
// hmb_cell_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hmb_cell_ram #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 31,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/hmb_locate.sv
// ----------------------------------------------------------------------------
// hmb_locate
// Two-stage cell locator: scale products, then cell index and range check.
// ----------------------------------------------------------------------------
module hmb_locate (
    input  logic                clk,
    input  hmb_pkg::loc_ctrl_t  ctrl,
    input  logic                op,
    input  logic signed [15:0]  point_x,
    input  logic signed [15:0]  point_z,
    input  logic [15:0]         read_cell,
    input  logic [8:0]          cells_across,
    input  logic [8:0]          cells_deep,
    input  logic [15:0]         x_scale,
    input  logic [15:0]         z_scale,
    output hmb_pkg::loc_res_t   res
);

    logic signed [32:0]                 prod_x_reg;
    logic signed [32:0]                 prod_z_reg;
    logic [hmb_pkg::IDX_SUM_W-1:0]      total_reg;
    hmb_pkg::loc_res_t                  res_reg;

    logic signed [16:0]                 col;
    logic signed [16:0]                 row;
    logic                               col_ok;
    logic                               row_ok;
    logic [hmb_pkg::IDX_SUM_W-1:0]      idx_sum;
    logic [hmb_pkg::IDX_SUM_W-1:0]      rc_ext;
    logic                               pt_ok;
    logic                               rd_ok;
    logic                               ok;
    logic [hmb_pkg::IDX_SUM_W-1:0]      sel_idx;

    // divide by 65536 rounding toward zero
    function automatic logic signed [16:0] trunc_bin(input logic signed [32:0] p);
        logic signed [32:0] adj;
        begin
            adj = p + (p[32] ? 33'sd65535 : 33'sd0);
            return adj[32:16];
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (ctrl.load_prod)
        begin
            prod_x_reg <= 33'(point_x) * 33'($signed({1'b0, x_scale}));
            prod_z_reg <= 33'(point_z) * 33'($signed({1'b0, z_scale}));
            total_reg  <= hmb_pkg::IDX_SUM_W'(cells_across) *
                          hmb_pkg::IDX_SUM_W'(cells_deep);
        end
    end

    always_comb
    begin
        col     = trunc_bin(prod_x_reg);
        row     = trunc_bin(prod_z_reg);
        col_ok  = !col[16] && (col[15:0] < {7'b0, cells_across});
        row_ok  = !row[16] && (row[15:0] < {7'b0, cells_deep});
        idx_sum = hmb_pkg::IDX_SUM_W'(row[8:0]) * hmb_pkg::IDX_SUM_W'(cells_across)
                + hmb_pkg::IDX_SUM_W'(col[8:0]);
        pt_ok   = col_ok && row_ok &&
                  (idx_sum < hmb_pkg::IDX_SUM_W'(hmb_pkg::MAX_CELLS));
        rc_ext  = hmb_pkg::IDX_SUM_W'(read_cell);
        rd_ok   = (rc_ext < total_reg) &&
                  (rc_ext < hmb_pkg::IDX_SUM_W'(hmb_pkg::MAX_CELLS));
        ok      = (op == hmb_pkg::OP_READ) ? rd_ok : pt_ok;
        sel_idx = (op == hmb_pkg::OP_READ) ? rc_ext : idx_sum;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_idx)
        begin
            res_reg.in_grid <= ok;
            res_reg.idx     <= ok ? sel_idx[hmb_pkg::CELL_IDX_W-1:0] : '0;
        end
    end

    assign res = res_reg;

endmodule

FILE: src/height_map_binning.sv
// ----------------------------------------------------------------------------
// height_map_binning
// Ground-grid max-height binning of 3D points with per-cell counts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request: add a point
//   (operation 0, point_x/point_height/point_z) or read and clear a cell
//   (operation 1, read_cell). Every request yields exactly one result on the
//   output channel (out_valid/out_ready).
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) sets grid size,
//   scales and min_points; write it only while no request is in flight.
//   Flow: a request walks the MUL, IDX, RD and WB states of the single
//   sequencer (scale multiply, index compute, cell RAM read, write-back) and
//   is taken only in IDLE, so a new request waits until the last leaves WB.
//   Reset: both cell stores are cleared by a pass over the cell RAM, one
//   entry a cycle; in_ready stays low meanwhile.
//   Stall: a finished result waits in the output register; the next request
//   is taken and worked up to the write-back, which holds until the output
//   register frees.
// ----------------------------------------------------------------------------
module height_map_binning (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    // request channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_height,
    input  logic signed [15:0] point_z,
    input  logic [15:0]        read_cell,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic               in_grid,
    output logic [15:0]        cell_index,
    output logic [14:0]        kept_height,
    output logic [14:0]        raw_height,
    output logic [15:0]        point_count
);

    `include "assert_macros.svh"

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_MUL  = 6'b000100,
        S_IDX  = 6'b001000,
        S_RD   = 6'b010000,
        S_WB   = 6'b100000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [hmb_pkg::CELL_IDX_W-1:0]  clr_cnt_reg;
    logic [hmb_pkg::CELL_IDX_W-1:0]  clr_cnt_next;

    // configuration registers
    logic [8:0]  cells_across_reg;
    logic [8:0]  cells_deep_reg;
    logic [15:0] x_scale_reg;
    logic [15:0] z_scale_reg;
    logic [15:0] min_points_reg;

    // captured request
    logic               op_reg;
    logic signed [15:0] x_reg;
    logic signed [15:0] h_reg;
    logic signed [15:0] z_reg;
    logic [15:0]        rc_reg;

    // output register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        in_grid_reg;
    logic [15:0] cell_index_reg;
    logic [14:0] kept_reg;
    logic [14:0] raw_reg;
    logic [15:0] count_reg;

    hmb_pkg::loc_ctrl_t loc_ctrl;
    hmb_pkg::loc_res_t  loc_res;

    logic                            ram_we;
    logic [hmb_pkg::CELL_IDX_W-1:0]  ram_waddr;
    logic [hmb_pkg::CELL_W-1:0]      ram_wdata;
    logic                            ram_re;
    logic [hmb_pkg::CELL_W-1:0]      ram_rdata;

    hmb_pkg::cell_t cur_cell;
    hmb_pkg::cell_t upd_cell;
    logic           out_free;
    logic           wb_fire;
    logic [14:0]    res_kept;
    logic [14:0]    res_raw;
    logic [15:0]    res_count;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign wb_fire   = (state_reg == S_WB) && out_free;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_across_reg <= 9'd64;
            cells_deep_reg   <= 9'd64;
            x_scale_reg      <= 16'd419;
            z_scale_reg      <= 16'd419;
            min_points_reg   <= 16'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hmb_pkg::CFG_CELLS_ACROSS: cells_across_reg <= cfg_data[8:0];
                hmb_pkg::CFG_CELLS_DEEP:   cells_deep_reg   <= cfg_data[8:0];
                hmb_pkg::CFG_X_SCALE:      x_scale_reg      <= cfg_data;
                hmb_pkg::CFG_Z_SCALE:      z_scale_reg      <= cfg_data;
                hmb_pkg::CFG_MIN_POINTS:   min_points_reg   <= cfg_data;
                default:                   ; // drop writes beyond the register list
            endcase
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            S_CLR:
            begin
                clr_cnt_next = clr_cnt_reg + hmb_pkg::CELL_IDX_W'(1);
                if (clr_cnt_reg == hmb_pkg::CELL_IDX_W'(hmb_pkg::MAX_CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:   state_next = S_IDX;
            S_IDX:   state_next = S_RD;
            S_RD:    state_next = S_WB;
            S_WB:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // capture the request at accept
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg <= operation;
            x_reg  <= point_x;
            h_reg  <= point_height;
            z_reg  <= point_z;
            rc_reg <= read_cell;
        end
    end

    // ---------------------------------------------------------------- locate
    assign loc_ctrl.load_prod = (state_reg == S_MUL);
    assign loc_ctrl.load_idx  = (state_reg == S_IDX);

    hmb_locate u_locate (
        .clk          (clk),
        .ctrl         (loc_ctrl),
        .op           (op_reg),
        .point_x      (x_reg),
        .point_z      (z_reg),
        .read_cell    (rc_reg),
        .cells_across (cells_across_reg),
        .cells_deep   (cells_deep_reg),
        .x_scale      (x_scale_reg),
        .z_scale      (z_scale_reg),
        .res          (loc_res)
    );

    // ---------------------------------------------------------------- cell RAM
    hmb_cell_ram #(
        .DEPTH (hmb_pkg::MAX_CELLS),
        .WIDTH (hmb_pkg::CELL_W)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (loc_res.idx),
        .rdata (ram_rdata)
    );

    assign ram_re = (state_reg == S_RD) && loc_res.in_grid;

    // modify: add keeps the max height (floor 0) and bumps the count;
    // read returns the cell and writes it back cleared
    always_comb
    begin
        cur_cell = hmb_pkg::cell_t'(ram_rdata);
        upd_cell = cur_cell;
        if (!h_reg[15] && (h_reg[14:0] > cur_cell.height))
        begin
            upd_cell.height = h_reg[14:0];
        end
        if (cur_cell.count != hmb_pkg::COUNT_MAX)
        begin
            upd_cell.count = cur_cell.count + 16'd1;
        end

        if (!loc_res.in_grid)
        begin
            res_kept  = '0;
            res_raw   = '0;
            res_count = '0;
        end
        else if (op_reg == hmb_pkg::OP_READ)
        begin
            res_kept  = (cur_cell.count < min_points_reg) ? 15'd0 : cur_cell.height;
            res_raw   = cur_cell.height;
            res_count = cur_cell.count;
        end
        else
        begin
            res_kept  = '0;
            res_raw   = upd_cell.height;
            res_count = upd_cell.count;
        end

        if (state_reg == S_CLR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = wb_fire && loc_res.in_grid;
            ram_waddr = loc_res.idx;
            ram_wdata = (op_reg == hmb_pkg::OP_READ) ? '0 : hmb_pkg::CELL_W'(upd_cell);
        end
    end

    // ---------------------------------------------------------------- output
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (wb_fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wb_fire)
        begin
            in_grid_reg    <= loc_res.in_grid;
            cell_index_reg <= 16'(loc_res.idx);
            kept_reg       <= res_kept;
            raw_reg        <= res_raw;
            count_reg      <= res_count;
        end
    end

    assign out_valid   = out_valid_reg;
    assign in_grid     = in_grid_reg;
    assign cell_index  = cell_index_reg;
    assign kept_height = kept_reg;
    assign raw_height  = raw_reg;
    assign point_count = count_reg;

    // ---------------------------------------------------------------- checks
    `ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && in_ready, state_reg == S_MUL)
    `ASSERT_IMPLY(a_write_owner, clk, rst_n, ram_we, state_reg == S_CLR || state_reg == S_WB)
    `ASSERT_IMPLY(a_outside_zero, clk, rst_n, out_valid && !in_grid,
                  cell_index == 16'd0 && raw_height == 15'd0 && point_count == 16'd0)
    `ASSERT_IMPLY(a_kept_is_raw, clk, rst_n, out_valid,
                  kept_height == 15'd0 || kept_height == raw_height)

endmodule

FILE: test/tb_height_map_binning.sv
// ----------------------------------------------------------------------------
// tb_height_map_binning
// Self-checking bench for the height-map binning block: a short table of
// requests, most hand-checked, then randomized point and read traffic over
// several grid settings, scored against an in-bench model of both cell stores.
// ----------------------------------------------------------------------------
module tb_height_map_binning;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int ITEMS_PER_PLAN = 65;
    // adds piled onto one cell during the no-idle stretch
    localparam int STEADY_ADDS    = 40;
    // cycles to let pass after the last result before touching registers
    localparam int SETTLE_CYCLES  = 8;

    // writes outside the register list; the block must drop them
    localparam logic [7:0] CFG_PAST_END = hmb_pkg::CFG_MIN_POINTS + 8'd1;
    localparam logic [7:0] CFG_UNUSED   = 8'hFF;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] x;
        logic signed [15:0] height;
        logic signed [15:0] z;
        logic [15:0]        read_cell;
    } bin_request_t;

    typedef struct packed {
        logic        in_grid;
        logic [15:0] cell_index;
        logic [14:0] kept_height;
        logic [14:0] raw_height;
        logic [15:0] point_count;
    } bin_result_t;

    // one row of the directed table; typed marks a hand-worked result
    typedef struct packed {
        logic               operation;
        logic signed [15:0] x;
        logic signed [15:0] height;
        logic signed [15:0] z;
        logic [15:0]        read_cell;
        logic               typed;
        logic               in_grid;
        logic [15:0]        cell_index;
        logic [14:0]        kept_height;
        logic [14:0]        raw_height;
        logic [15:0]        point_count;
    } directed_row_t;

    typedef struct packed {
        logic [15:0] across;
        logic [15:0] deep;
        logic [15:0] x_scale;
        logic [15:0] z_scale;
        logic [15:0] min_points;
    } grid_plan_t;

    // Directed requests, run under the reset register values
    // (64 x 64 cells, scales 419/65536, min_points 2).
    localparam int NUM_DIRECTED = 24;
    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // fresh stores read back as zero; first and last valid cell
        '{hmb_pkg::OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'd0,
          1'b1, 1'b1, 16'd0, 15'd0, 15'd0, 16'd0},
        '{hmb_pkg::OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'd4095,
          1'b1, 1'b1, 16'd4095, 15'd0, 15'd0, 16'd0},
        // read index past the grid and at the top of the field
        '{hmb_pkg::OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'd4096,
          1'b1, 1'b0, 16'd0, 15'd0, 15'd0, 16'd0},
        '{hmb_pkg::OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'd65535,
          1'b1, 1'b0, 16'd0, 15'd0, 15'd0, 16'd0},
        // plain add to cell (6,6), then read: count 1 is below min_points
        '{hmb_pkg::OP_ADD, 16'sd1000, 16'sd500, 16'sd1000, 16'd0,
          1'b1, 1'b1, 16'd390, 15'd0, 15'd500, 16'd1},
        '{hmb_pkg::OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'd390,
          1'b1, 1'b1, 16'd390, 15'd0, 15'd500, 16'd1},
        // small negative coordinates truncate to cell 0; negative height floors
        '{hmb_pkg::OP_ADD, -16'sd100, -16'sd500, -16'sd100, 16'd0,
          1'b1, 1'b1, 16'd0, 15'd0, 15'd0, 16'd1},
        // column -1, column 209, both coordinates at the negative extreme
        '{hmb_pkg::OP_ADD, -16'sd200, 16'sd32767, 16'sd0, 16'd0,
          1'b1, 1'b0, 16'd0, 15'd0, 15'd0, 16'd0},
        '{hmb_pkg::OP_ADD, 16'sd32767, 16'sd32767, 16'sd0, 16'd0,
          1'b1, 1'b0, 16'd0, 15'd0, 15'd0, 16'd0},
        '{hmb_pkg::OP_ADD, -16'sd32768, -16'sd32768, -16'sd32768, 16'd0,
          1'b1, 1'b0, 16'd0, 15'd0, 15'd0, 16'd0},
        // height extremes on cell 0: the maximum holds against the minimum
        '{hmb_pkg::OP_ADD, 16'sd0, 16'sd32767, 16'sd0, 16'd0,
          1'b1, 1'b1, 16'd0, 15'd0, 15'd32767, 16'd2},
        '{hmb_pkg::OP_ADD, 16'sd0, -16'sd32768, 16'sd0, 16'd0,
          1'b1, 1'b1, 16'd0, 15'd0, 15'd32767, 16'd3},
        // read keeps the height at count 3, then a second read sees it cleared
        '{hmb_pkg::OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'd0,
          1'b1, 1'b1, 16'd0, 15'd32767, 15'd32767, 16'd3},
        '{hmb_pkg::OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'd0,
          1'b1, 1'b1, 16'd0, 15'd0, 15'd0, 16'd0},
        // last column and row, then one step past each edge
        '{hmb_pkg::OP_ADD, 16'sd10010, 16'sd100, 16'sd10010, 16'd0,
          1'b1, 1'b1, 16'd4095, 15'd0, 15'd100, 16'd1},
        '{hmb_pkg::OP_ADD, 16'sd10011, 16'sd100, 16'sd0, 16'd0,
          1'b1, 1'b0, 16'd0, 15'd0, 15'd0, 16'd0},
        '{hmb_pkg::OP_ADD, 16'sd0, 16'sd100, 16'sd10011, 16'd0,
          1'b1, 1'b0, 16'd0, 15'd0, 15'd0, 16'd0},
        '{hmb_pkg::OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'd4095,
          1'b1, 1'b1, 16'd4095, 15'd0, 15'd100, 16'd1},
        // ordinary traffic, scored by the model
        '{hmb_pkg::OP_ADD, 16'sd5000, 16'sd1234, 16'sd3000, 16'd0,
          1'b0, 1'b0, 16'd0, 15'd0, 15'd0, 16'd0},
        '{hmb_pkg::OP_ADD, 16'sd5100, -16'sd7, 16'sd3050, 16'd0,
          1'b0, 1'b0, 16'd0, 15'd0, 15'd0, 16'd0},
        '{hmb_pkg::OP_ADD, 16'sd5000, 16'sd2000, 16'sd3000, 16'd0,
          1'b0, 1'b0, 16'd0, 15'd0, 15'd0, 16'd0},
        '{hmb_pkg::OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'd1247,
          1'b0, 1'b0, 16'd0, 15'd0, 15'd0, 16'd0},
        '{hmb_pkg::OP_ADD, 16'sd0, 16'sd16384, 16'sd32767, 16'd0,
          1'b0, 1'b0, 16'd0, 15'd0, 15'd0, 16'd0},
        '{hmb_pkg::OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'd12345,
          1'b0, 1'b0, 16'd0, 15'd0, 15'd0, 16'd0}
    };

    // Grid settings for the random phases. Width and depth carry 16-bit
    // data so that bits above the 9-bit register are dropped on the way in.
    localparam int NUM_PLANS = 6;
    localparam grid_plan_t GRID_PLANS [NUM_PLANS] = '{
        // tiny grid, scale at its top, every height kept
        '{16'd8, 16'd4, 16'd65535, 16'd65535, 16'd0},
        // largest legal grid
        '{16'd256, 16'd256, 16'd2048, 16'd2048, 16'd3},
        // single cell, zero scales: every point lands in cell 0
        '{16'd1, 16'd1, 16'd0, 16'd0, 16'd1},
        // width masks down to zero: nothing is ever in the grid
        '{16'hFE00, 16'd64, 16'd419, 16'd419, 16'hFFFF},
        // 511 x 511: cell index overflows the store
        '{16'hFFFF, 16'hFFFF, 16'd65535, 16'd65535, 16'd2},
        // lopsided grid and scales
        '{16'd200, 16'd37, 16'd1000, 16'd300, 16'd2}
    };

    // no-idle run: reset geometry, min_points inside the pile-up range
    localparam grid_plan_t STEADY_PLAN = '{16'd64, 16'd64, 16'd419, 16'd419, 16'd20};

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [7:0]         cfg_index    = '0;
    logic [15:0]        cfg_data     = '0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic               operation    = hmb_pkg::OP_ADD;
    logic signed [15:0] point_x      = '0;
    logic signed [15:0] point_height = '0;
    logic signed [15:0] point_z      = '0;
    logic [15:0]        read_cell    = '0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic               in_grid;
    logic [15:0]        cell_index;
    logic [14:0]        kept_height;
    logic [14:0]        raw_height;
    logic [15:0]        point_count;

    // model copy of the registers, at reset values
    logic [8:0]  grid_across    = 9'd64;
    logic [8:0]  grid_deep      = 9'd64;
    logic [15:0] scale_x        = 16'd419;
    logic [15:0] scale_z        = 16'd419;
    logic [15:0] keep_threshold = 16'd2;

    // model copy of the two cell stores
    logic [14:0] grid_height [hmb_pkg::MAX_CELLS];
    logic [15:0] grid_count  [hmb_pkg::MAX_CELLS];

    bin_result_t pending_results [$];
    logic [15:0] recent_cells [$];
    bit          steady      = 1'b0;
    int          error_count = 0;

    height_map_binning i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .point_x      (point_x),
        .point_height (point_height),
        .point_z      (point_z),
        .read_cell    (read_cell),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .in_grid      (in_grid),
        .cell_index   (cell_index),
        .kept_height  (kept_height),
        .raw_height   (raw_height),
        .point_count  (point_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Stall the result side at random, about 16 percent of the time; hold ready
    // high throughout the steady stretch.
    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(99) >= 16);
    end

    // Column or row of a coordinate: exact product, truncated toward zero.
    function automatic longint grid_coord(input logic signed [15:0] coord,
                                          input logic [15:0] scale);
        return (longint'($signed(coord)) * longint'(scale)) / 65536;
    endfunction

    // Apply one request to the model stores and return the result it yields.
    function automatic bin_result_t bin_item(input bin_request_t r);
        bin_result_t res;
        longint      col;
        longint      row;
        longint      idx;
        longint      cells;
        logic [15:0] slot;
        logic [14:0] peak;
        res = '0;
        if (r.operation == hmb_pkg::OP_ADD)
        begin
            col = grid_coord(r.x, scale_x);
            row = grid_coord(r.z, scale_z);
            if (col < 0 || row < 0 || col >= longint'(grid_across) ||
                row >= longint'(grid_deep))
                return res;
            idx = row * longint'(grid_across) + col;
            if (idx >= hmb_pkg::MAX_CELLS)
                return res;
            slot = idx[15:0];
            peak = grid_height[slot];
            if (int'($signed(r.height)) > int'(peak))
                peak = r.height[14:0];
            grid_height[slot] = peak;
            if (grid_count[slot] != hmb_pkg::COUNT_MAX)
                grid_count[slot] = grid_count[slot] + 16'd1;
            res = '{1'b1, slot, 15'd0, peak, grid_count[slot]};
        end
        else
        begin
            cells = longint'(grid_across) * longint'(grid_deep);
            if (longint'(r.read_cell) >= cells ||
                longint'(r.read_cell) >= hmb_pkg::MAX_CELLS)
                return res;
            slot = r.read_cell;
            res.in_grid     = 1'b1;
            res.cell_index  = slot;
            res.raw_height  = grid_height[slot];
            res.point_count = grid_count[slot];
            res.kept_height = (grid_count[slot] < keep_threshold) ? 15'd0 : grid_height[slot];
            grid_height[slot] = '0;
            grid_count[slot]  = '0;
        end
        return res;
    endfunction

    // Widest coordinate that still reaches a cell one past the grid edge.
    function automatic longint coord_span(input logic [8:0] cells,
                                          input logic [15:0] scale);
        longint span;
        if (scale == 0)
            return 32767;
        span = (longint'(cells) + 1) * 65536 / longint'(scale);
        return (span > 32767) ? 32767 : span;
    endfunction

    // Mostly well-aimed requests: points around the live grid, reads of recently
    // hit or in-grid cells; one in eight is raw noise over the full field widths.
    function automatic bin_request_t random_request();
        bin_request_t r;
        longint       span_x;
        longint       span_z;
        longint       cells;
        r.operation = ($urandom_range(99) < 30) ? hmb_pkg::OP_READ : hmb_pkg::OP_ADD;
        r.x         = 16'($urandom_range(65535));
        r.height    = 16'($urandom_range(65535));
        r.z         = 16'($urandom_range(65535));
        r.read_cell = 16'($urandom_range(65535));
        if ($urandom_range(7) == 0)
            return r;
        span_x = coord_span(grid_across, scale_x);
        span_z = coord_span(grid_deep, scale_z);
        r.x = 16'(longint'($urandom_range(32'(span_x))) - span_x / 8 - 2);
        r.z = 16'(longint'($urandom_range(32'(span_z))) - span_z / 8 - 2);
        if ($urandom_range(1) == 0)
            r.height = 16'($urandom_range(2000));
        cells = longint'(grid_across) * longint'(grid_deep);
        if (cells > hmb_pkg::MAX_CELLS)
            cells = hmb_pkg::MAX_CELLS;
        if (r.operation == hmb_pkg::OP_READ && cells != 0)
        begin
            if (recent_cells.size() != 0 && $urandom_range(1) == 0)
                r.read_cell = recent_cells[$urandom_range(recent_cells.size() - 1)];
            else
                r.read_cell = 16'($urandom_range(32'(cells - 1)));
        end
        return r;
    endfunction

    // Mirror an accepted register write into the model.
    function automatic void store_reg(input logic [7:0] index, input logic [15:0] value);
        case (index)
            hmb_pkg::CFG_CELLS_ACROSS: grid_across    = value[8:0];
            hmb_pkg::CFG_CELLS_DEEP:   grid_deep      = value[8:0];
            hmb_pkg::CFG_X_SCALE:      scale_x        = value;
            hmb_pkg::CFG_Z_SCALE:      scale_z        = value;
            hmb_pkg::CFG_MIN_POINTS:   keep_threshold = value;
            default: ;
        endcase
    endfunction

    // Write all five registers back to back, then one stray index.
    task automatic program_grid(input grid_plan_t plan, input logic [7:0] stray_index);
        logic [7:0]  reg_index [6];
        logic [15:0] reg_value [6];
        reg_index = '{hmb_pkg::CFG_CELLS_ACROSS, hmb_pkg::CFG_CELLS_DEEP,
                      hmb_pkg::CFG_X_SCALE, hmb_pkg::CFG_Z_SCALE,
                      hmb_pkg::CFG_MIN_POINTS, stray_index};
        reg_value = '{plan.across, plan.deep, plan.x_scale, plan.z_scale,
                      plan.min_points, 16'($urandom_range(65535))};
        for (int k = 0; k < 6; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_index[k];
            cfg_data  <= reg_value[k];
            do @(posedge clk); while (!cfg_ready);
            store_reg(reg_index[k], reg_value[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Present one request, hold it until accepted, and queue its result.
    // Valid stays high on return so back-to-back requests need no bubble.
    task automatic send_request(input bin_request_t r, input bit typed,
                                input bin_result_t typed_result);
        bin_result_t predicted;
        while (!steady && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= r.operation;
        point_x      <= r.x;
        point_height <= r.height;
        point_z      <= r.z;
        read_cell    <= r.read_cell;
        do @(posedge clk); while (!in_ready);
        predicted = bin_item(r);
        pending_results = {pending_results, (typed ? typed_result : predicted)};
        if (r.operation == hmb_pkg::OP_ADD && predicted.in_grid)
        begin
            recent_cells = {recent_cells, predicted.cell_index};
            if (recent_cells.size() > 32)
                void'(recent_cells.pop_front());
        end
    endtask

    // Drop valid, wait for every outstanding result, then wait SETTLE_CYCLES
    // more before anything touches the registers.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endtask

    // Score every accepted result against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        bin_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual cell %0d",
                         $time, cell_index);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("in_grid", 16'(want.in_grid), 16'(in_grid));
                check_field("cell_index", want.cell_index, cell_index);
                check_field("kept_height", 16'(want.kept_height), 16'(kept_height));
                check_field("raw_height", 16'(want.raw_height), 16'(raw_height));
                check_field("point_count", want.point_count, point_count);
            end
        end
    end

    initial
    begin : stimulus
        bin_request_t req;
        bin_result_t  typed_result;
        bin_request_t bump;

        foreach (grid_height[i])
        begin
            grid_height[i] = '0;
            grid_count[i]  = '0;
        end

        // Hold reset low and release it; the block then clears its stores,
        // which the first request simply waits out on in_ready.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table under the reset register values.
        foreach (DIRECTED_ROWS[i])
        begin
            req = '{DIRECTED_ROWS[i].operation, DIRECTED_ROWS[i].x,
                    DIRECTED_ROWS[i].height, DIRECTED_ROWS[i].z,
                    DIRECTED_ROWS[i].read_cell};
            typed_result = '{DIRECTED_ROWS[i].in_grid, DIRECTED_ROWS[i].cell_index,
                             DIRECTED_ROWS[i].kept_height, DIRECTED_ROWS[i].raw_height,
                             DIRECTED_ROWS[i].point_count};
            send_request(req, DIRECTED_ROWS[i].typed, typed_result);
        end
        settle();

        // Random traffic under each grid setting. Halfway through a phase,
        // hold the sender until the pipeline has fully drained.
        foreach (GRID_PLANS[p])
        begin
            program_grid(GRID_PLANS[p], (p % 2 == 1) ? CFG_UNUSED : CFG_PAST_END);
            for (int n = 0; n < ITEMS_PER_PLAN; n++)
            begin
                if (n == ITEMS_PER_PLAN / 2)
                    settle();
                send_request(random_request(), 1'b0, '0);
            end
            settle();
        end

        // Pile adds onto cell 0 with no idling on either side, then read it
        // back against the min_points threshold.
        program_grid(STEADY_PLAN, CFG_PAST_END);
        steady <= 1'b1;
        for (int n = 0; n < STEADY_ADDS; n++)
        begin
            bump = '{hmb_pkg::OP_ADD, 16'($urandom_range(150)), 16'($urandom_range(65535)),
                     16'($urandom_range(150)), 16'd0};
            send_request(bump, 1'b0, '0);
        end
        bump = '{hmb_pkg::OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'd0};
        send_request(bump, 1'b0, '0);
        settle();
        steady <= 1'b0;

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Stop a hung run: covers the store clear after reset and all request
    // phases many times over.
    initial
    begin : watchdog
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/hmb_pkg.sv
src/hmb_cell_ram.sv
src/hmb_locate.sv
src/height_map_binning.sv
test/tb_height_map_binning.sv
